[sv/channel_number_hash_table_defines.svh]
// Assertion macros for the channel number hash table.
// Used by the modules in this folder; needs aclk and aresetn in scope.
`ifndef CHANNEL_NUMBER_HASH_TABLE_DEFINES_SVH
`define CHANNEL_NUMBER_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, masked while in reset
`define CNHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked property, also during reset
`define CNHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CNHT_ASSERT(lbl, prop, msg)
`define CNHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/cnht_pkg.sv]
// Shared types and constants for the channel number hash table.
// No dependencies.
package cnht_pkg;

    // table geometry
    localparam int BUCKETS       = 16;
    localparam int MAIN_WAYS     = 4;
    localparam int OVERFLOW_WAYS = 4;
    localparam int WAYS          = MAIN_WAYS + OVERFLOW_WAYS;
    localparam int SLOTS         = BUCKETS * WAYS;

    // field widths
    localparam int CH_W   = 16;
    localparam int REL_W  = 7;
    localparam int FUNC_W = 2;

    // index widths
    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_BIND    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input beat, read the bucket row
        logic commit;    // resolve, update table, load result register
    } cnht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or draining this cycle
    } cnht_sts_t;

endpackage

[sv/cnht_ctrl.sv]
// Controller for the channel number hash table: sequences capture and commit.
// Depends on cnht_pkg.
module cnht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cnht_pkg::cnht_sts_t sts,
    output cnht_pkg::cnht_cmd_t cmd
);
    import cnht_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the beat
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/cnht_dpath.sv]
// Datapath for the channel number hash table: channel store, valid bits,
// way compare and result register. Depends on cnht_pkg and the defines header.
`include "channel_number_hash_table_defines.svh"
module cnht_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cnht_pkg::cnht_cmd_t     cmd,
    output cnht_pkg::cnht_sts_t     sts,
    input  cnht_pkg::func_t         in_func,
    input  logic [cnht_pkg::CH_W-1:0]  in_chan,
    input  logic [cnht_pkg::REL_W-1:0] in_rel,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] hit, [7:1] found_slot, [8] full_res, rest zero
    output logic [15:0]             m_tdata
);
    import cnht_pkg::*;

    // channel store, one row per bucket
    logic [CH_W-1:0] chan_mem [BUCKETS][WAYS];
    logic [CH_W-1:0] row_reg  [WAYS];

    logic [SLOTS-1:0] valid_reg;

    func_t            func_reg;
    logic [CH_W-1:0]  chan_reg;
    logic [REL_W-1:0] rel_reg;
    logic [BKT_W-1:0] bucket_reg;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [REL_W-1:0] out_slot_reg;
    logic             out_full_reg;

    logic [BKT_W-1:0]      in_bucket;
    logic [SLOT_IDX_W-1:0] base_idx;
    logic [WAYS-1:0]       row_valid;
    logic [WAYS-1:0]       match;
    logic                  any_match;
    logic                  any_free;
    logic [WAY_W-1:0]      match_way;
    logic [WAY_W-1:0]      free_way;
    logic [SLOT_IDX_W-1:0] match_idx;
    logic [SLOT_IDX_W-1:0] bind_idx;
    logic [SLOT_IDX_W-1:0] rel_idx;
    logic                  rel_in_range;
    logic                  bind_ok;
    logic                  res_hit;
    logic [REL_W-1:0]      res_slot;
    logic                  res_full;

    // bucket select: modulo by the bucket count
    assign in_bucket = BKT_W'(32'(in_chan) % BUCKETS);

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg   <= in_func;
            chan_reg   <= in_chan;
            rel_reg    <= in_rel;
            bucket_reg <= in_bucket;
        end
    end

    // store: registered row read on capture, single way write on bind
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            row_reg <= chan_mem[in_bucket];
        end
        if (cmd.commit && bind_ok) begin
            chan_mem[bucket_reg][free_way] <= chan_reg;
        end
    end

    // parallel way compare on the captured row
    assign base_idx  = SLOT_IDX_W'(32'(bucket_reg) * WAYS);
    assign row_valid = valid_reg[base_idx +: WAYS];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = row_valid[w] && (row_reg[w] == chan_reg);
        end
    end

    // first matching way and first free way, lowest index wins
    always_comb begin
        match_way = '0;
        free_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                match_way = WAY_W'(w);
            end
            if (!row_valid[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign any_match    = |match;
    assign any_free     = ~&row_valid;
    assign match_idx    = base_idx + SLOT_IDX_W'(match_way);
    assign bind_idx     = base_idx + SLOT_IDX_W'(free_way);
    assign rel_idx      = SLOT_IDX_W'(rel_reg);
    assign rel_in_range = (32'(rel_reg) < SLOTS);
    assign bind_ok      = (func_reg == FUNC_BIND) && any_free;

    // result per operation
    always_comb begin
        res_hit  = 1'b0;
        res_slot = '0;
        res_full = 1'b0;
        unique case (func_reg)
            FUNC_LOOKUP: begin
                res_hit  = any_match;
                res_slot = any_match ? REL_W'(match_idx) : '0;
            end
            FUNC_BIND: begin
                res_hit  = any_free;
                res_slot = any_free ? REL_W'(bind_idx) : '0;
                res_full = !any_free;
            end
            FUNC_RELEASE: begin
                res_hit  = rel_in_range && valid_reg[rel_idx];
                res_slot = rel_reg;
            end
            FUNC_CLEAR: begin
                res_hit = 1'b0;
            end
            default: res_hit = 1'b0;
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit) begin
            if (func_reg == FUNC_CLEAR) begin
                valid_reg <= '0;
            end else if (bind_ok) begin
                valid_reg[bind_idx] <= 1'b1;
            end else if (func_reg == FUNC_RELEASE && rel_in_range) begin
                valid_reg[rel_idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg  <= res_hit;
            out_slot_reg <= res_slot;
            out_full_reg <= res_full;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {7'b0, out_full_reg, out_slot_reg, out_hit_reg};

    // checks
    `CNHT_ASSERT(a_commit_loads, cmd.commit |=> m_tvalid, "commit did not load a result")
    `CNHT_ASSERT(a_clear_empties, (cmd.commit && func_reg == FUNC_CLEAR) |=> (valid_reg == '0), "clear left valid slots")
    `CNHT_ASSERT(a_bind_sets_valid, (cmd.commit && bind_ok) |=> valid_reg[$past(bind_idx)], "bound slot not marked valid")
    `CNHT_ASSERT_ALWAYS(a_no_overlap, !(cmd.capture && cmd.commit), "capture and commit in the same cycle")

endmodule

[sv/channel_number_hash_table.sv]
// Channel number hash table: lookup, bind, release and clear of channel slots.
// The beat is registered, then the result register loads once the output is free.
// No new beat until the last commits (row read, then compare and write back).
// A stalled result holds the next item in the compare stage until it drains.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass.
module channel_number_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] channel_number, [22:16] release_slot, [23] zero
    input  logic [23:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] hit, [7:1] found_slot, [8] full_res, [15:9] zero
    output logic [15:0] m_tdata
);
    import cnht_pkg::*;

    cnht_cmd_t cmd;
    cnht_sts_t sts;
    func_t     in_func;

    assign in_func = func_t'(s_tuser);

    // sequencing
    cnht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and result path
    cnht_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_func  (in_func),
        .in_chan  (s_tdata[15:0]),
        .in_rel   (s_tdata[22:16]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
